// File: rtl/core/rtpj_pkg.sv
// ============================================================================
// rtpj_pkg : shared types and constants for the RTP receiver block
// Field widths, request and response payloads, CSR indexes, sequencer states
// and the constants of the sequence and jitter arithmetic.
// ============================================================================
package rtpj_pkg;

   // field widths
   localparam int unsigned SEQ_W     = 16;
   localparam int unsigned TS_W      = 32;
   localparam int unsigned ARR_W     = 48;
   localparam int unsigned SIZE_W    = 16;
   localparam int unsigned EXT_W     = 32;
   localparam int unsigned JIT_W     = 32;
   localparam int unsigned PKT_W     = 32;
   localparam int unsigned BYTES_W   = 40;
   localparam int unsigned PROB_W    = 4;
   localparam int unsigned DROP_W    = 16;
   localparam int unsigned MISO_W    = 15;
   localparam int unsigned RATE_W    = 24;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 24;

   // arrival-to-timestamp scaling: (arrival diff * rate) / 10^6
   localparam int unsigned US_PER_S  = 1000000;
   localparam int unsigned REM_W     = $clog2(US_PER_S);
   localparam int unsigned HALF_W    = ARR_W / 2;
   localparam int unsigned PROD_W    = ARR_W + RATE_W;
   localparam int unsigned DIGIT_W   = 8;
   localparam int unsigned DIV_STEPS = PROD_W / DIGIT_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // sequence constants
   localparam logic [SEQ_W:0] SEQ_MOD  = {1'b1, {SEQ_W{1'b0}}};
   localparam logic [SEQ_W:0] BAD_NONE = SEQ_MOD + (SEQ_W + 1)'(1);

   // CSR reset values
   localparam logic [PROB_W-1:0] PROB_RESET = PROB_W'(2);
   localparam logic [DROP_W-1:0] DROP_RESET = DROP_W'(3000);
   localparam logic [MISO_W-1:0] MISO_RESET = MISO_W'(100);
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(90000);

   typedef enum logic {
      OP_START  = 1'b0,
      OP_PACKET = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROBATION    = 2'd0,
      CSR_MAX_DROPOUT  = 2'd1,
      CSR_MAX_MISORDER = 2'd2,
      CSR_CLOCK_RATE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [SEQ_W-1:0]    seq_num;
      logic [TS_W-1:0]     media_timestamp;
      logic [ARR_W-1:0]    arrival_us;
      logic [SIZE_W-1:0]   packet_size;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [EXT_W-1:0]    extended_seq;
      logic [SEQ_W-1:0]    base_sequence;
      logic [JIT_W-1:0]    jitter_q4;
      logic [PKT_W-1:0]    packets_seen;
      logic [BYTES_W-1:0]  bytes_seen;
   } rsp_type;

   typedef struct packed {
      logic [PROB_W-1:0]   probation_count;
      logic [DROP_W-1:0]   max_dropout;
      logic [MISO_W-1:0]   max_misorder;
      logic [RATE_W-1:0]   clock_rate_hz;
   } cfg_type;

   // verdict of the sequence tracker for one request
   typedef struct packed {
      logic accepted;
      logic init;
   } judge_type;

   // status of the scaling unit
   typedef struct packed {
      logic busy;
      logic done;
   } scale_status_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MUL_LO,
      SC_MUL_HI,
      SC_ACC,
      SC_DIV,
      SC_DONE
   } scale_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_JUDGE,
      ST_SCALE,
      ST_DIFF,
      ST_FILTER,
      ST_RESULT
   } ctrl_state_type;

endpackage

// File: rtl/core/rtpj_seq_track.sv
// ============================================================================
// rtpj_seq_track : RTP sequence number validation
// Holds the sequence state of one source and judges each request against it:
// probation, in-order with wrap counting, resync on a large jump, misorder.
// ============================================================================
module rtpj_seq_track import rtpj_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              judge_en,
   input  opcode_type        opcode,
   input  logic [SEQ_W-1:0]  seq_num,
   input  cfg_type           cfg,
   output judge_type         judge,
   output logic [EXT_W-1:0]  extended_seq,
   output logic [SEQ_W-1:0]  base_sequence
);

   logic [SEQ_W-1:0]  last_ff,  last_in;
   logic [SEQ_W:0]    bad_ff,   bad_in;
   logic [SEQ_W-1:0]  first_ff, first_in;
   logic [SEQ_W-1:0]  wrap_ff,  wrap_in;
   logic [PROB_W-1:0] prob_ff,  prob_in;

   logic [SEQ_W-1:0]  delta;
   logic [SEQ_W:0]    jump_sum;

   assign delta    = seq_num - last_ff;
   assign jump_sum = {1'b0, delta} + {2'b00, cfg.max_misorder};

   // judge logic
   always_comb begin
      last_in  = last_ff;
      bad_in   = bad_ff;
      first_in = first_ff;
      wrap_in  = wrap_ff;
      prob_in  = prob_ff;
      judge    = '0;
      if (judge_en) begin
         if (opcode == OP_START) begin
            // new source: probation starts one below the given number
            last_in    = seq_num - SEQ_W'(1);
            first_in   = seq_num;
            bad_in     = BAD_NONE;
            wrap_in    = '0;
            prob_in    = cfg.probation_count;
            judge.init = 1'b1;
         end else if (prob_ff != '0) begin
            // probation: must step by exactly one, no wrap
            if (last_ff != '1 && last_ff + SEQ_W'(1) == seq_num) begin
               last_in = seq_num;
               prob_in = prob_ff - PROB_W'(1);
               if (prob_ff == PROB_W'(1)) begin
                  first_in       = seq_num;
                  bad_in         = BAD_NONE;
                  wrap_in        = '0;
                  judge.accepted = 1'b1;
                  judge.init     = 1'b1;
               end
            end else begin
               prob_in = cfg.probation_count;
               last_in = seq_num;
            end
         end else if (delta < cfg.max_dropout) begin
            // in order, count a wrap of the 16-bit number
            if (seq_num < last_ff) begin
               wrap_in = wrap_ff + SEQ_W'(1);
            end
            last_in        = seq_num;
            judge.accepted = 1'b1;
         end else if (jump_sum <= SEQ_MOD) begin
            // large jump: resync only on the directly following packet
            if (bad_ff == {1'b0, seq_num}) begin
               last_in        = seq_num;
               first_in       = seq_num;
               bad_in         = BAD_NONE;
               wrap_in        = '0;
               judge.accepted = 1'b1;
               judge.init     = 1'b1;
            end else begin
               bad_in = {1'b0, seq_num + SEQ_W'(1)};
            end
         end else begin
            // misorder or duplicate
            judge.accepted = 1'b1;
         end
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         bad_ff   <= BAD_NONE;
         first_ff <= '0;
         wrap_ff  <= '0;
         prob_ff  <= '0;
      end else begin
         last_ff  <= last_in;
         bad_ff   <= bad_in;
         first_ff <= first_in;
         wrap_ff  <= wrap_in;
         prob_ff  <= prob_in;
      end
   end

   assign extended_seq  = {wrap_ff, last_ff};
   assign base_sequence = first_ff;

endmodule

// File: rtl/core/rtpj_scale_unit.sv
// ============================================================================
// rtpj_scale_unit : arrival time to media clock scaling
// Computes floor(diff * rate / 10^6) mod 2^32 with one shared 24x24
// multiplier used twice and a long divider taking eight bits per step.
// ============================================================================
module rtpj_scale_unit import rtpj_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ARR_W-1:0]   diff,
   input  logic [RATE_W-1:0]  rate,
   output scale_status_type   status,
   output logic [TS_W-1:0]    scaled
);

   localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(US_PER_S);

   scale_state_type        phase_ff, phase_in;
   logic [DIV_CNT_W-1:0]   step_ff;
   logic [ARR_W-1:0]       diff_ff;
   logic [RATE_W-1:0]      rate_ff;
   logic [2*HALF_W-1:0]    prod_ff;
   logic [PROD_W-1:0]      dividend_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [TS_W-1:0]        quot_ff;

   logic [HALF_W-1:0]      mul_a;
   logic [2*HALF_W-1:0]    mul_out;
   logic [REM_W-1:0]       div_rem;
   logic [DIGIT_W-1:0]     div_q;

   // shared multiplier: low half of the difference first, then the high half
   assign mul_a   = (phase_ff == SC_MUL_HI) ? diff_ff[ARR_W-1:HALF_W] : diff_ff[HALF_W-1:0];
   assign mul_out = mul_a * rate_ff;

   // one divider step: eight restoring quotient bits
   always_comb begin
      logic [REM_W:0]   trial;
      logic [REM_W-1:0] r;
      r     = rem_ff;
      div_q = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         trial = {r, dividend_ff[PROD_W-1-i]};
         if (trial >= DIVISOR) begin
            trial              = trial - DIVISOR;
            div_q[DIGIT_W-1-i] = 1'b1;
         end
         r = trial[REM_W-1:0];
      end
      div_rem = r;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         SC_IDLE:   if (start) phase_in = SC_MUL_LO;
         SC_MUL_LO: phase_in = SC_MUL_HI;
         SC_MUL_HI: phase_in = SC_ACC;
         SC_ACC:    phase_in = SC_DIV;
         SC_DIV:    if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) phase_in = SC_DONE;
         SC_DONE:   phase_in = SC_IDLE;
         default:   phase_in = SC_IDLE;
      endcase
   end

   // status outputs
   always_comb begin
      status.busy = (phase_ff != SC_IDLE);
      status.done = (phase_ff == SC_DONE);
      scaled      = quot_ff;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SC_IDLE;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         if (phase_ff == SC_ACC) begin
            step_ff <= '0;
         end else if (phase_ff == SC_DIV) begin
            step_ff <= step_ff + DIV_CNT_W'(1);
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (phase_ff)
         SC_IDLE: begin
            if (start) begin
               diff_ff <= diff;
               rate_ff <= rate;
            end
         end
         SC_MUL_LO: prod_ff <= mul_out;
         SC_MUL_HI: begin
            dividend_ff <= {{(PROD_W - 2*HALF_W){1'b0}}, prod_ff};
            prod_ff     <= mul_out;
         end
         SC_ACC: begin
            dividend_ff <= dividend_ff + {prod_ff, {HALF_W{1'b0}}};
            rem_ff      <= '0;
            quot_ff     <= '0;
         end
         SC_DIV: begin
            dividend_ff <= {dividend_ff[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            rem_ff      <= div_rem;
            quot_ff     <= {quot_ff[TS_W-DIGIT_W-1:0], div_q};
         end
         default: ;
      endcase
   end

endmodule

// File: rtl/core/rtp_receiver_seq_and_jitter.sv
// ============================================================================
// rtp_receiver_seq_and_jitter : RTP source sequence and jitter tracker
// Top level: request capture, sequencer, jitter filter, counters, CSRs.
// ============================================================================
// Usage:
//   req_*  : one request per item, opcode start (init source) or packet.
//   rsp_*  : exactly one response per request with the verdict and the
//            source state after the request.
//   csr_*  : register writes (probation, dropout, misorder, clock rate);
//            csr_ready is always high, write only while the block is idle.
// Request flow:
//   A request that needs no jitter update (start, rejected packet, first
//   accepted packet after init) passes the judge and result states. An
//   accepted packet with a jitter update also passes the scale, difference
//   and filter states and waits in the scale state for the scaling unit:
//   two passes of its 24x24 multiplier and nine 8-bit steps of the divide
//   by 10^6. req_ready is high only while the sequencer is idle, so one
//   request is processed at a time.
// Reset and stall:
//   Synchronous reset returns the CSRs to their defaults and clears all
//   source state. A response waits in the output register while rsp_ready
//   is low; the next request is taken meanwhile and parks in the result
//   state until the register frees.
// ============================================================================
module rtp_receiver_seq_and_jitter import rtpj_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   ctrl_state_type     state_ff, state_in;
   cfg_type            cfg_ff;
   req_type            req_ff;
   logic               acc_ff;
   logic [TS_W-1:0]    tsd_ff;
   logic [JIT_W-1:0]   mag_ff;
   logic [JIT_W-1:0]   jitter_ff, jitter_in;
   logic [PKT_W-1:0]   pkt_ff,    pkt_in;
   logic [BYTES_W-1:0] bytes_ff,  bytes_in;
   logic [ARR_W-1:0]   prev_arr_ff, prev_arr_in;
   logic [TS_W-1:0]    prev_ts_ff,  prev_ts_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   judge_type          judge;
   logic [EXT_W-1:0]   extended_seq;
   logic [SEQ_W-1:0]   base_sequence;
   scale_status_type   scale_status;
   logic [TS_W-1:0]    scaled;
   logic               judge_en;
   logic               scale_start;
   logic               need_jit;
   logic               rsp_free;
   logic               rsp_load;
   logic [TS_W-1:0]    dev;
   logic [JIT_W:0]     filt_sum;
   logic [JIT_W:0]     filt_decay;
   logic [JIT_W:0]     filt_next;

   // sequence tracker
   rtpj_seq_track u_seq (
      .clock         (clock),
      .reset         (reset),
      .judge_en      (judge_en),
      .opcode        (req_ff.opcode),
      .seq_num       (req_ff.seq_num),
      .cfg           (cfg_ff),
      .judge         (judge),
      .extended_seq  (extended_seq),
      .base_sequence (base_sequence)
   );

   // arrival scaling unit
   rtpj_scale_unit u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .diff   (req_ff.arrival_us - prev_arr_ff),
      .rate   (cfg_ff.clock_rate_hz),
      .status (scale_status),
      .scaled (scaled)
   );

   // jitter needs a previous accepted packet of the same source
   assign need_jit = judge.accepted && !judge.init && (pkt_ff != '0);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_JUDGE;
         ST_JUDGE:  state_in = need_jit ? ST_SCALE : ST_RESULT;
         ST_SCALE:  if (scale_status.done) state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_FILTER;
         ST_FILTER: state_in = ST_RESULT;
         ST_RESULT: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      judge_en    = (state_ff == ST_JUDGE);
      scale_start = (state_ff == ST_JUDGE) && need_jit;
      rsp_load    = (state_ff == ST_RESULT) && rsp_free;
   end

   // jitter filter arithmetic
   assign dev        = scaled - tsd_ff;
   assign filt_sum   = {1'b0, jitter_ff} + {1'b0, mag_ff};
   assign filt_decay = ({1'b0, jitter_ff} + (JIT_W + 1)'(8)) >> 4;
   assign filt_next  = filt_sum - filt_decay;

   // source counters
   always_comb begin
      jitter_in   = jitter_ff;
      pkt_in      = pkt_ff;
      bytes_in    = bytes_ff;
      prev_arr_in = prev_arr_ff;
      prev_ts_in  = prev_ts_ff;
      case (state_ff)
         ST_JUDGE: begin
            if (judge.init) begin
               jitter_in = '0;
               pkt_in    = '0;
               bytes_in  = '0;
            end
            if (judge.accepted && !need_jit) begin
               // first accepted packet: no jitter sample yet
               jitter_in   = '0;
               pkt_in      = (judge.init ? '0 : pkt_ff) + PKT_W'(1);
               bytes_in    = (judge.init ? '0 : bytes_ff)
                           + {{(BYTES_W - SIZE_W){1'b0}}, req_ff.packet_size};
               prev_arr_in = req_ff.arrival_us;
               prev_ts_in  = req_ff.media_timestamp;
            end
         end
         ST_FILTER: begin
            jitter_in   = filt_next[JIT_W] ? '1 : filt_next[JIT_W-1:0];
            pkt_in      = pkt_ff + PKT_W'(1);
            bytes_in    = bytes_ff + {{(BYTES_W - SIZE_W){1'b0}}, req_ff.packet_size};
            prev_arr_in = req_ff.arrival_us;
            prev_ts_in  = req_ff.media_timestamp;
         end
         default: ;
      endcase
   end

   // control and source state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         jitter_ff    <= '0;
         pkt_ff       <= '0;
         bytes_ff     <= '0;
         prev_arr_ff  <= '0;
         prev_ts_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         jitter_ff    <= jitter_in;
         pkt_ff       <= pkt_in;
         bytes_ff     <= bytes_in;
         prev_arr_ff  <= prev_arr_in;
         prev_ts_ff   <= prev_ts_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture and working registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_JUDGE) begin
         acc_ff <= judge.accepted;
         tsd_ff <= req_ff.media_timestamp - prev_ts_ff;
      end
      if (state_ff == ST_DIFF) begin
         mag_ff <= dev[TS_W-1] ? (TS_W'(0) - dev) : dev;
      end
      if (rsp_load) begin
         rsp_ff.accepted      <= acc_ff;
         rsp_ff.extended_seq  <= extended_seq;
         rsp_ff.base_sequence <= base_sequence;
         rsp_ff.jitter_q4     <= jitter_ff;
         rsp_ff.packets_seen  <= pkt_ff;
         rsp_ff.bytes_seen    <= bytes_ff;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.probation_count <= PROB_RESET;
         cfg_ff.max_dropout     <= DROP_RESET;
         cfg_ff.max_misorder    <= MISO_RESET;
         cfg_ff.clock_rate_hz   <= RATE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROBATION:    cfg_ff.probation_count <= csr_wdata[PROB_W-1:0];
            CSR_MAX_DROPOUT:  cfg_ff.max_dropout     <= csr_wdata[DROP_W-1:0];
            CSR_MAX_MISORDER: cfg_ff.max_misorder    <= csr_wdata[MISO_W-1:0];
            CSR_CLOCK_RATE:   cfg_ff.clock_rate_hz   <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // scaling unit finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      scale_status.done |-> state_ff == ST_SCALE)
      else $error("scale unit done outside of scale state");

   // scaling unit is never restarted while busy
   assert property (@(posedge clock) disable iff (reset)
      scale_start |-> !scale_status.busy)
      else $error("scale unit started while busy");

   // the first packet counted after init carries no jitter
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.accepted && rsp_data.packets_seen == PKT_W'(1))
      |-> rsp_data.jitter_q4 == '0)
      else $error("jitter not cleared on first packet");

endmodule

// File: tb/rtp_receiver_seq_and_jitter_test.sv
`timescale 1ns / 100ps
// ============================================================================
// rtp_receiver_seq_and_jitter_test : RTP sequence and jitter tracker test
// Drives start and packet requests through the valid/ready request port and
// checks every response field against a local model of the source tracker
// (probation, wrap counting, jump resync, misorder, fixed-point jitter).
// A short directed list comes first, then random phases. Each phase writes
// a new CSR setting while the block is idle. Both ports idle and stall at
// random, and one long response hold-off backs the block up.
// ============================================================================
module rtp_receiver_seq_and_jitter_test;
   import rtpj_pkg::*;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct packed {
      logic    is_preset;
      rsp_type value;
   } preset_status_type;

   typedef struct packed {
      req_type stim;
      logic    is_preset;
      rsp_type value;
   } directed_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [23:0]   csr_wdata;

   // model of the source state and the CSR settings
   cfg_type       csr_shadow;
   logic [15:0]   src_last;
   logic [16:0]   src_bad;
   logic [15:0]   src_first;
   logic [15:0]   src_wraps;
   logic [3:0]    src_probation;
   logic [31:0]   src_packets;
   logic [39:0]   src_bytes;
   logic [31:0]   src_jitter;
   logic [47:0]   src_prev_arrival;
   logic [31:0]   src_prev_ts;

   rsp_type           expected_status_q [$];
   preset_status_type preset_q [$];
   directed_row_type  directed_q [$];
   int                fail_count;

   // random stream state
   logic [15:0]   gen_seq;
   logic [31:0]   gen_ts;
   logic [47:0]   gen_arr;
   logic          resync_due;
   int unsigned   run_left;
   logic          req_idle_on;
   logic          rsp_idle_on;
   logic          hold_rsp;

   rtp_receiver_seq_and_jitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #6000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // source model
   // ------------------------------------------------------------------------
   function automatic void init_source(logic [15:0] seq);
      src_last      = seq;
      src_bad       = BAD_NONE;
      src_first     = seq;
      src_wraps     = '0;
      src_probation = '0;
      src_packets   = '0;
      src_bytes     = '0;
      src_jitter    = '0;
   endfunction

   function automatic rsp_type track_source(req_type r);
      logic [15:0] step;
      logic        take;
      logic [71:0] ticks;
      logic [31:0] skew;
      logic [31:0] mag;
      logic [33:0] filt;
      rsp_type     status;
      take = 1'b0;
      step = r.seq_num - src_last;
      if (r.opcode == OP_START) begin
         init_source(r.seq_num);
         src_last      = r.seq_num - 16'd1;
         src_probation = csr_shadow.probation_count;
      end else if (src_probation != 0) begin
         // probation: next sequence number required, no wrap allowed
         if ({1'b0, src_last} + 17'd1 == {1'b0, r.seq_num}) begin
            src_last      = r.seq_num;
            src_probation = src_probation - 4'd1;
            if (src_probation == 0) begin
               init_source(r.seq_num);
               take = 1'b1;
            end
         end else begin
            src_probation = csr_shadow.probation_count;
            src_last      = r.seq_num;
         end
      end else if (step < csr_shadow.max_dropout) begin
         if (r.seq_num < src_last)
            src_wraps = src_wraps + 16'd1;
         src_last = r.seq_num;
         take     = 1'b1;
      end else if ({1'b0, step} <= 17'h10000 - {2'b00, csr_shadow.max_misorder}) begin
         // large jump: accepted only when the next packet follows it
         if (src_bad == {1'b0, r.seq_num}) begin
            init_source(r.seq_num);
            take = 1'b1;
         end else begin
            src_bad = {1'b0, r.seq_num + 16'd1};
         end
      end else begin
         take = 1'b1;
      end

      if (take) begin
         if (src_packets != 0) begin
            ticks = ({24'd0, r.arrival_us - src_prev_arrival}
                     * {48'd0, csr_shadow.clock_rate_hz}) / 72'd1000000;
            skew  = ticks[31:0] - (r.media_timestamp - src_prev_ts);
            mag   = skew[31] ? -skew : skew;
            filt  = {2'b00, src_jitter} + {2'b00, mag}
                    - (({2'b00, src_jitter} + 34'd8) >> 4);
            src_jitter = (filt > 34'h0FFFFFFFF) ? 32'hFFFF_FFFF : filt[31:0];
         end else begin
            src_jitter = '0;
         end
         src_prev_arrival = r.arrival_us;
         src_prev_ts      = r.media_timestamp;
         src_bytes        = src_bytes + {24'd0, r.packet_size};
         src_packets      = src_packets + 32'd1;
      end

      status.accepted      = take;
      status.extended_seq  = {src_wraps, src_last};
      status.base_sequence = src_first;
      status.jitter_q4     = src_jitter;
      status.packets_seen  = src_packets;
      status.bytes_seen    = src_bytes;
      return status;
   endfunction

   // ------------------------------------------------------------------------
   // response check, CSR tracking and request prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : status_check
      rsp_type           want;
      preset_status_type preset;
      if (reset) begin
         csr_shadow       = {PROB_RESET, DROP_RESET, MISO_RESET, RATE_RESET};
         init_source('0);
         src_prev_arrival = '0;
         src_prev_ts      = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_status_q.pop_front();
               if (want.accepted !== rsp_data.accepted) begin
                  $error("accepted: expected %0d, got %0d",
                         want.accepted, rsp_data.accepted);
                  fail_count++;
               end
               if (want.extended_seq !== rsp_data.extended_seq) begin
                  $error("extended_seq: expected %0h, got %0h",
                         want.extended_seq, rsp_data.extended_seq);
                  fail_count++;
               end
               if (want.base_sequence !== rsp_data.base_sequence) begin
                  $error("base_sequence: expected %0h, got %0h",
                         want.base_sequence, rsp_data.base_sequence);
                  fail_count++;
               end
               if (want.jitter_q4 !== rsp_data.jitter_q4) begin
                  $error("jitter_q4: expected %0h, got %0h",
                         want.jitter_q4, rsp_data.jitter_q4);
                  fail_count++;
               end
               if (want.packets_seen !== rsp_data.packets_seen) begin
                  $error("packets_seen: expected %0d, got %0d",
                         want.packets_seen, rsp_data.packets_seen);
                  fail_count++;
               end
               if (want.bytes_seen !== rsp_data.bytes_seen) begin
                  $error("bytes_seen: expected %0d, got %0d",
                         want.bytes_seen, rsp_data.bytes_seen);
                  fail_count++;
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROBATION:    csr_shadow.probation_count = csr_wdata[3:0];
               CSR_MAX_DROPOUT:  csr_shadow.max_dropout     = csr_wdata[15:0];
               CSR_MAX_MISORDER: csr_shadow.max_misorder    = csr_wdata[14:0];
               CSR_CLOCK_RATE:   csr_shadow.clock_rate_hz   = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            want   = track_source(req_data);
            preset = (preset_q.size() != 0) ? preset_q.pop_front() : '0;
            expected_status_q.push_back(preset.is_preset ? preset.value : want);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // often back to back, sometimes a short gap, rarely a long gap
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // well-formed packet streams with random content, plus some noise
   function automatic req_type next_request();
      req_type     r;
      int unsigned pick;
      pick    = $urandom_range(0, 99);
      gen_ts  = gen_ts + 32'($urandom_range(0, 6000));
      gen_arr = gen_arr + 48'($urandom_range(0, 70000));
      r.opcode          = OP_PACKET;
      r.media_timestamp = gen_ts;
      r.arrival_us      = gen_arr;
      r.packet_size     = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(40, 1500));
      if (resync_due) begin
         // packet right after a jump completes the resync
         r.seq_num  = gen_seq + 16'd1;
         resync_due = 1'b0;
      end else if (run_left != 0 || pick < 50) begin
         if (run_left == 0)
            run_left = $urandom_range(0, 12);
         else
            run_left--;
         r.seq_num = gen_seq + 16'd1;
      end else if (pick < 55) begin
         r.opcode  = OP_START;
         r.seq_num = 16'($urandom);
         run_left  = $urandom_range(0, 20);
      end else if (pick < 63) begin
         r.seq_num = gen_seq + 16'($urandom_range(2, 4000));
      end else if (pick < 72) begin
         r.seq_num = gen_seq - 16'($urandom_range(0, 150));
      end else if (pick < 82) begin
         r.seq_num  = gen_seq + 16'($urandom_range(5000, 60000));
         resync_due = ($urandom_range(0, 3) != 0);
      end else begin
         r.opcode          = opcode_type'($urandom_range(0, 1));
         r.seq_num         = 16'($urandom);
         r.media_timestamp = $urandom;
         r.arrival_us      = {16'($urandom), 32'($urandom)};
         r.packet_size     = 16'($urandom);
      end
      gen_seq = (r.opcode == OP_START) ? r.seq_num - 16'd1 : r.seq_num;
      return r;
   endfunction

   // offer one request and hold it until the block takes it
   task automatic send_request(req_type r, logic is_preset, rsp_type value);
      int unsigned gap;
      gap = req_idle_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      preset_q.push_back({is_preset, value});
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic add_row(opcode_type op, logic [15:0] seq, logic [31:0] ts,
                          logic [47:0] arr, logic [15:0] size,
                          logic is_preset, rsp_type value);
      directed_row_type row;
      row.stim      = {op, seq, ts, arr, size};
      row.is_preset = is_preset;
      row.value     = value;
      directed_q.push_back(row);
   endtask

   task automatic write_csr(csr_index_type idx, logic [23:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic write_config(cfg_type c);
      write_csr(CSR_PROBATION,    24'(c.probation_count));
      write_csr(CSR_MAX_DROPOUT,  24'(c.max_dropout));
      write_csr(CSR_MAX_MISORDER, 24'(c.max_misorder));
      write_csr(CSR_CLOCK_RATE,   c.clock_rate_hz);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop the request valid and wait for every response to come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response side: random stalls and one long hold-off
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned stall;
      stall     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1)
               @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall != 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (rsp_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            stall = pick_gap();
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      cfg_type phase_cfg [PHASES];
      fail_count  = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_PROBATION;
      csr_wdata   = '0;
      gen_seq     = '0;
      gen_ts      = '0;
      gen_arr     = '0;
      resync_due  = 1'b0;
      run_left    = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      hold_rsp    = 1'b0;

      // probation, dropout, misorder, clock rate
      phase_cfg[0] = {4'd2,  16'd3000,  15'd100,   24'd90000};
      phase_cfg[1] = {4'd0,  16'd1,     15'd1,     24'd1};
      phase_cfg[2] = {4'd15, 16'd32768, 15'd32767, 24'd16777215};
      phase_cfg[3] = {4'd1,  16'd3000,  15'd0,     24'd8000};
      phase_cfg[4] = {4'd3,  16'd500,   15'd50,    24'd48000};
      phase_cfg[5] = {4'd2,  16'd3000,  15'd100,   24'd90000};

      repeat (5)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed list, reset CSR values; fields: accepted, extended seq,
      // base, jitter, packets, bytes
      // packet straight after reset is in order against sequence zero
      add_row(OP_PACKET, 16'd5, 32'd1000, 48'd0, 16'd100,
              1'b1, {1'b1, 32'd5, 16'd0, 32'd0, 32'd1, 40'd100});
      add_row(OP_START, 16'd0, 32'd0, 48'd0, 16'd0,
              1'b1, {1'b0, 32'h0000FFFF, 16'd0, 32'd0, 32'd0, 40'd0});
      // probation never matches across the wrap
      add_row(OP_PACKET, 16'd0, 32'd0, 48'd0, 16'd0,
              1'b1, {1'b0, 32'd0, 16'd0, 32'd0, 32'd0, 40'd0});
      add_row(OP_PACKET, 16'd1, 32'd0, 48'd0, 16'd0,
              1'b1, {1'b0, 32'd1, 16'd0, 32'd0, 32'd0, 40'd0});
      // probation complete: source starts over, first packet has no jitter
      add_row(OP_PACKET, 16'd2, 32'd0, 48'd1000, 16'hFFFF,
              1'b1, {1'b1, 32'd2, 16'd2, 32'd0, 32'd1, 40'd65535});
      add_row(OP_PACKET, 16'd3, 32'd90, 48'd2000, 16'd0,
              1'b1, {1'b1, 32'd3, 16'd2, 32'd0, 32'd2, 40'd65535});
      add_row(OP_PACKET, 16'd4, 32'd90, 48'd3000, 16'd0,
              1'b1, {1'b1, 32'd4, 16'd2, 32'd90, 32'd3, 40'd65535});
      // large jump rejected, then the following packet resyncs
      add_row(OP_PACKET, 16'd40000, 32'd0, 48'd0, 16'd1,
              1'b1, {1'b0, 32'd4, 16'd2, 32'd90, 32'd3, 40'd65535});
      add_row(OP_PACKET, 16'd40001, 32'd500, 48'd50000, 16'd10,
              1'b1, {1'b1, 32'd40001, 16'd40001, 32'd0, 32'd1, 40'd10});
      // misorder, then duplicate
      add_row(OP_PACKET, 16'd39990, 32'd1400, 48'd60000, 16'd20, 1'b0, '0);
      add_row(OP_PACKET, 16'd40001, 32'd1500, 48'd61000, 16'd30, 1'b0, '0);
      // all-ones fields, then sequence and arrival wrap
      add_row(OP_START, 16'd65534, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd0,
              1'b1, {1'b0, 32'h0000FFFD, 16'd65534, 32'd0, 32'd0, 40'd0});
      add_row(OP_PACKET, 16'd65534, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd0, 1'b0, '0);
      add_row(OP_PACKET, 16'd65535, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd7, 1'b0, '0);
      add_row(OP_PACKET, 16'd0, 32'd10, 48'd100, 16'hFFFF, 1'b0, '0);
      // timestamp steps of half the range: most negative difference, saturation
      add_row(OP_PACKET, 16'd1, 32'h8000_000A, 48'd100, 16'd1, 1'b0, '0);
      add_row(OP_PACKET, 16'd2, 32'd10, 48'd100, 16'd1, 1'b0, '0);
      add_row(OP_PACKET, 16'd3, 32'h8000_000A, 48'd100, 16'd1, 1'b0, '0);
      // dropout and misorder boundaries
      add_row(OP_PACKET, 16'd3002, 32'd20, 48'd200, 16'd1, 1'b0, '0);
      add_row(OP_PACKET, 16'd6002, 32'd30, 48'd300, 16'd1, 1'b0, '0);
      add_row(OP_PACKET, 16'd2902, 32'd40, 48'd400, 16'd1, 1'b0, '0);
      add_row(OP_PACKET, 16'd2903, 32'd50, 48'd500, 16'd1, 1'b0, '0);
      add_row(OP_START, 16'hFFFF, 32'd0, 48'd0, 16'd0,
              1'b1, {1'b0, 32'h0000FFFE, 16'hFFFF, 32'd0, 32'd0, 40'd0});
      add_row(OP_PACKET, 16'hFFFF, 32'd0, 48'd0, 16'd0, 1'b0, '0);
      add_row(OP_PACKET, 16'd0, 32'd0, 48'd0, 16'd0, 1'b0, '0);

      foreach (directed_q[i])
         send_request(directed_q[i].stim, directed_q[i].is_preset, directed_q[i].value);

      // random phases, one CSR setting each
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_config(phase_cfg[p]);
         req_idle_on = (p != 0 && p != PHASES - 1);
         rsp_idle_on = (p != 0);
         hold_rsp    = (p == PHASES - 1);
         repeat (ITEMS_PER_PHASE)
            send_request(next_request(), 1'b0, '0);
      end

      wait_idle();
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: rtp_receiver_seq_and_jitter.f
rtl/core/rtpj_pkg.sv
rtl/core/rtpj_seq_track.sv
rtl/core/rtpj_scale_unit.sv
rtl/core/rtp_receiver_seq_and_jitter.sv
tb/rtp_receiver_seq_and_jitter_test.sv
